// ===== rtl/core/ssa_pkg.sv =====
package ssa_pkg;

   // Request kinds carried on req_type.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   // Outcome of the block choice made when an allocate word is taken.
   typedef struct packed {
      logic keep;      // the current block still has room
      logic create;    // no created block has room, a new one is made
      logic no_space;  // every block exists and all are full
   } pick_type;

endpackage

// ===== rtl/core/slab_slot_allocator_core.sv =====
// Slot allocator over a set of slab blocks, each with a free list threaded
// through its slots.
//
// Input channel: a word is taken at a rising edge where start is high and
// busy is low. req_type selects allocate or free; req_free_block and
// req_free_slot name the slot to free and are ignored on allocate.
// Result channel: every word taken yields one result word, shown for one
// cycle with rsp_valid high. The receiver cannot stall, so results are
// never held.
// Sequence: an allocate that finds room reads the block record, then the
// link of its head slot, and busy stays high until the slot is popped; its
// registered result is on the ports as busy falls. A free of a created block
// reads the block record and the slot link together, with busy high, and then
// shows its result. An allocate that finds no space and a free that names an
// uncreated block or a slot out of range answer without raising busy, so
// the next word may follow at once.
// Reset: a clearing pass rewrites every slot link and block record; busy
// stays high until it is done.
module slab_slot_allocator_core
   import ssa_pkg::*;
#(
   parameter int NUM_BLOCKS      = 8,
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int PREALLOC_BLOCKS = 1
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_type,
   input  logic [2:0] req_free_block,
   input  logic [5:0] req_free_slot,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_got_block,
   output logic [5:0] rsp_got_slot,
   output logic [3:0] rsp_empty_blocks,
   output logic [3:0] rsp_created_blocks
);

   localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int SIW = $clog2(SLOTS_PER_BLOCK);
   localparam int LW  = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int CW  = $clog2(NUM_BLOCKS + 1);
   localparam int AW  = BW + SIW;
   localparam int INIT_MADE =
      (PREALLOC_BLOCKS < NUM_BLOCKS) ? PREALLOC_BLOCKS : NUM_BLOCKS;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_HEAD,
      S_ALLOC_LINK,
      S_FREE_CHECK
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [NUM_BLOCKS-1:0] full_v_ff, full_v_in;
   logic [NUM_BLOCKS-1:0] empty_v_ff, empty_v_in;
   logic [CW-1:0]       made_ff, made_in;
   logic [CW-1:0]       empty_cnt_ff, empty_cnt_in;
   logic [BW-1:0]       cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [BW-1:0]       blk_ff, blk_in;
   logic [LW-1:0]       head_ff, head_in;
   logic [LW-1:0]       count_ff, count_in;
   logic [SIW-1:0]      slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [BW-1:0]       rsp_block_ff, rsp_block_in;
   logic [SIW-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [CW-1:0]       rsp_empty_ff, rsp_empty_in;
   logic [CW-1:0]       rsp_made_ff, rsp_made_in;

   pick_type            pick;
   logic [BW-1:0]       pick_block;

   logic                slot_wr_en, slot_rd_en;
   logic [AW-1:0]       slot_wr_addr, slot_rd_addr;
   logic [LW:0]         slot_wr_data, slot_rd_data;
   logic                blk_wr_en, blk_rd_en;
   logic [BW-1:0]       blk_wr_addr, blk_rd_addr;
   logic [2*LW-1:0]     blk_wr_data, blk_rd_data;
   logic [LW-1:0]       rd_count, rd_head;

   logic                accept;
   logic                free_ok;
   logic                cnt_dec;
   logic [LW-1:0]       cnt_src, cnt_sum;

   assign accept   = start && !busy;
   assign rd_count = blk_rd_data[2*LW-1:LW];
   assign rd_head  = blk_rd_data[LW-1:0];
   assign free_ok  = (32'(req_free_block) < 32'(made_ff)) &&
                     (32'(req_free_slot) < SLOTS_PER_BLOCK);

   // Slot links with in-use flags, one word per slot.
   ssa_ram #(
      .WIDTH (LW + 1),
      .DEPTH (2 ** AW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // Per-block use count and free list head.
   ssa_ram #(
      .WIDTH (2 * LW),
      .DEPTH (2 ** BW)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_en   (blk_rd_en),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   // Choice of block for an allocate.
   ssa_pick #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_pick (
      .full_v      (full_v_ff),
      .blocks_made (made_ff),
      .cur_block   (cur_ff),
      .cur_valid   (cur_valid_ff),
      .pick        (pick),
      .pick_block  (pick_block)
   );

   // The one count adder, shared by allocate and free.
   assign cnt_dec = (state_ff == S_FREE_CHECK);
   assign cnt_src = cnt_dec ? rd_count : count_ff;
   assign cnt_sum = cnt_src + (cnt_dec ? {LW{1'b1}} : LW'(1));

   // Sequencer next state, memory ports and result word.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      full_v_in     = full_v_ff;
      empty_v_in    = empty_v_ff;
      made_in       = made_ff;
      empty_cnt_in  = empty_cnt_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      blk_in        = blk_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_block_in  = '0;
      rsp_slot_in   = '0;
      rsp_empty_in  = rsp_empty_ff;
      rsp_made_in   = rsp_made_ff;
      slot_wr_en    = 1'b0;
      slot_wr_addr  = '0;
      slot_wr_data  = '0;
      slot_rd_en    = 1'b0;
      slot_rd_addr  = '0;
      blk_wr_en     = 1'b0;
      blk_wr_addr   = '0;
      blk_wr_data   = '0;
      blk_rd_en     = 1'b0;
      blk_rd_addr   = '0;

      unique case (state_ff)
         // Sweep: each slot links to the next, each block record is zero.
         S_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_ff;
            slot_wr_data = {1'b0, LW'(clr_ff[SIW-1:0]) + LW'(1)};
            blk_wr_en    = 1'b1;
            blk_wr_addr  = clr_ff[BW-1:0];
            blk_wr_data  = '0;
            clr_in       = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end

         // Take a word and start its memory reads, or answer it directly when it fails.
         S_IDLE: begin
            if (accept && (req_type == REQ_ALLOC)) begin
               if (pick.no_space) begin
                  cur_valid_in  = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_SPACE;
                  rsp_empty_in  = empty_cnt_ff;
                  rsp_made_in   = made_ff;
               end else begin
                  if (pick.create) begin
                     made_in                = made_ff + CW'(1);
                     full_v_in[pick_block]  = 1'b0;
                     empty_v_in[pick_block] = 1'b0;
                  end
                  cur_in       = pick_block;
                  cur_valid_in = 1'b1;
                  blk_in       = pick_block;
                  blk_rd_en    = 1'b1;
                  blk_rd_addr  = pick_block;
                  state_in     = S_ALLOC_HEAD;
               end
            end else if (accept) begin
               if (free_ok) begin
                  blk_in       = BW'(req_free_block);
                  slot_in      = SIW'(req_free_slot);
                  blk_rd_en    = 1'b1;
                  blk_rd_addr  = BW'(req_free_block);
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = {BW'(req_free_block), SIW'(req_free_slot)};
                  state_in     = S_FREE_CHECK;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BAD_FREE;
                  rsp_empty_in  = empty_cnt_ff;
                  rsp_made_in   = made_ff;
               end
            end
         end

         // Block record is back: fetch the link of the head slot.
         S_ALLOC_HEAD: begin
            head_in  = rd_head;
            count_in = rd_count;
            if (32'(rd_head) >= SLOTS_PER_BLOCK) begin
               // An exhausted list with a stale count: treat as full.
               full_v_in[blk_ff]  = 1'b1;
               empty_v_in[blk_ff] = 1'b0;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = ST_NO_SPACE;
               rsp_empty_in       = empty_cnt_ff;
               rsp_made_in        = made_ff;
               state_in           = S_IDLE;
            end else begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = {blk_ff, rd_head[SIW-1:0]};
               state_in     = S_ALLOC_LINK;
            end
         end

         // Pop the head slot and update the block record and status.
         S_ALLOC_LINK: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = {blk_ff, head_ff[SIW-1:0]};
            slot_wr_data = {1'b1, slot_rd_data[LW-1:0]};
            blk_wr_en    = 1'b1;
            blk_wr_addr  = blk_ff;
            blk_wr_data  = {cnt_sum, slot_rd_data[LW-1:0]};
            if (empty_v_ff[blk_ff] && (empty_cnt_ff != '0)) begin
               empty_cnt_in = empty_cnt_ff - CW'(1);
            end
            empty_v_in[blk_ff] = 1'b0;
            full_v_in[blk_ff]  = (32'(cnt_sum) >= SLOTS_PER_BLOCK);
            rsp_valid_in       = 1'b1;
            rsp_status_in      = ST_OK;
            rsp_block_in       = blk_ff;
            rsp_slot_in        = head_ff[SIW-1:0];
            rsp_empty_in       = empty_cnt_in;
            rsp_made_in        = made_ff;
            state_in           = S_IDLE;
         end

         // Check the in-use flag, then push the slot on its block's list.
         S_FREE_CHECK: begin
            rsp_valid_in = 1'b1;
            if (!slot_rd_data[LW]) begin
               rsp_status_in = ST_BAD_FREE;
            end else begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = {blk_ff, slot_ff};
               slot_wr_data = {1'b0, rd_head};
               blk_wr_en    = 1'b1;
               blk_wr_addr  = blk_ff;
               blk_wr_data  = {cnt_sum, LW'(slot_ff)};
               full_v_in[blk_ff] = 1'b0;
               if (cnt_sum == '0) begin
                  empty_v_in[blk_ff] = 1'b1;
                  empty_cnt_in       = empty_cnt_ff + CW'(1);
               end
               if (!cur_valid_ff || (full_v_ff[cur_ff] && (cur_ff != blk_ff))) begin
                  cur_in       = blk_ff;
                  cur_valid_in = 1'b1;
               end
               rsp_status_in = ST_OK;
            end
            rsp_empty_in = empty_cnt_in;
            rsp_made_in  = made_ff;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State, block status and the registered result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         full_v_ff    <= '0;
         empty_v_ff   <= {{(NUM_BLOCKS-1){1'b1}}, 1'b0};
         made_ff      <= CW'(INIT_MADE);
         empty_cnt_ff <= CW'(INIT_MADE - 1);
         cur_ff       <= '0;
         cur_valid_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         full_v_ff    <= full_v_in;
         empty_v_ff   <= empty_v_in;
         made_ff      <= made_in;
         empty_cnt_ff <= empty_cnt_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff        <= blk_in;
      head_ff       <= head_in;
      count_ff      <= count_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_made_ff   <= rsp_made_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_got_block      = 3'(rsp_block_ff);
   assign rsp_got_slot       = 6'(rsp_slot_ff);
   assign rsp_empty_blocks   = 4'(rsp_empty_ff);
   assign rsp_created_blocks = 4'(rsp_made_ff);

   // The empty count never exceeds the number of created blocks.
   a_empty_le_made: assert property (@(posedge clock) disable iff (reset)
      empty_cnt_ff <= made_ff)
      else $error("empty block count exceeds created blocks");

   // The current block, while valid, is always a created one.
   a_cur_created: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (32'(cur_ff) < 32'(made_ff)))
      else $error("current block not created");

   // A failed word reports no slot.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_got_block == 3'd0 &&
                                               rsp_got_slot == 6'd0))
      else $error("failed result carries a slot");

   // No result word appears during the sweep, since busy is high throughout it.
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> !rsp_valid)
      else $error("result during clearing pass");

endmodule

// ===== rtl/core/ssa_ram.sv =====
module ssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssa_pick.sv =====
module ssa_pick
   import ssa_pkg::*;
#(
   parameter int NUM_BLOCKS = 8
) (
   input  logic [NUM_BLOCKS-1:0]                             full_v,
   input  logic [$clog2(NUM_BLOCKS+1)-1:0]                   blocks_made,
   input  logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] cur_block,
   input  logic                                              cur_valid,
   output pick_type                                          pick,
   output logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] pick_block
);

   localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);

   logic          found;
   logic [BW-1:0] found_block;

   // Priority encoder: the lowest created block that is not full.
   always_comb begin
      found       = 1'b0;
      found_block = '0;
      for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
         if ((CW'(b) < blocks_made) && !full_v[b]) begin
            found       = 1'b1;
            found_block = BW'(b);
         end
      end
   end

   // Keep the current block, take the found one, create one, or give up.
   always_comb begin
      pick       = '0;
      pick_block = cur_block;
      if (cur_valid && !full_v[cur_block]) begin
         pick.keep = 1'b1;
      end else if (found) begin
         pick_block = found_block;
      end else if (32'(blocks_made) < NUM_BLOCKS) begin
         pick.create = 1'b1;
         pick_block  = BW'(blocks_made);
      end else begin
         pick.no_space = 1'b1;
      end
   end

endmodule
